// ----- rtl/lca_pkg.sv -----
// shared constants, types and codes of the lowest common ancestor block
`default_nettype none

package lca_pkg;

	localparam int NODE_W     = 12;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int LEVELS     = 12;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int DEPTH_W    = 12;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0]   lvl_t;

	// one memory row: depth of the node and its ancestors 2^level steps up
	typedef struct packed {
		depth_t                  depth;
		node_t [LEVELS-1:0]      jump;
	} row_t;

	localparam depth_t DEPTH_MAX = '1;
	localparam lvl_t   LVL_TOP   = lvl_t'(LEVELS - 1);

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/lca_req_if.sv -----
// request channel: insert or query transaction
`default_nettype none

interface lca_req_if;
	import lca_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	node_t node_a;
	node_t node_b;

	modport source(output valid, output action, output node_a, output node_b, input ready);
	modport sink(input valid, input action, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/lca_rsp_if.sv -----
// response channel: common ancestor of a query
`default_nettype none

interface lca_rsp_if;
	import lca_pkg::*;

	logic  valid;
	logic  ready;
	node_t ancestor;

	modport source(output valid, output ancestor, input ready);
	modport sink(input valid, input ancestor, output ready);
endinterface

`default_nettype wire

// ----- rtl/lca_binary_lifting.sv -----
// lowest common ancestor by binary lifting over a single row memory
//
//  channel  dir  transaction carries          when
//  req      in   action, node_a, node_b       valid & ready
//  rsp      out  ancestor                     valid & ready, one per query
//
// after reset a clearing pass writes every one of the 4096 memory rows to zero,
// one row per cycle; req.ready stays low until the pass is done
// one transaction at a time: a query runs the order, lift, check, climb and final
// steps, and ends after the check when the lifted node already equals the other
// node; an insert runs the first, level and write steps; the run is set by the
// chain of dependent memory reads, one row read per level per cycle
// a finished result waits in the output register, so the block takes the next
// transaction while rsp is stalled; a second query waits for that register
`default_nettype none

module lca_binary_lifting (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lca_req_if.sink    req,
	lca_rsp_if.source  rsp
);
	import lca_pkg::*;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b00_0000_0001,
		ST_IDLE    = 10'b00_0000_0010,
		ST_Q_ORDER = 10'b00_0000_0100,
		ST_Q_LIFT  = 10'b00_0000_1000,
		ST_Q_CHECK = 10'b00_0001_0000,
		ST_Q_CLIMB = 10'b00_0010_0000,
		ST_Q_FINAL = 10'b00_0100_0000,
		ST_I_FIRST = 10'b00_1000_0000,
		ST_I_LEVEL = 10'b01_0000_0000,
		ST_I_WRITE = 10'b10_0000_0000
	} state_t;

	// row memory: one row per node, two read ports, one write port
	row_t mem [NODE_COUNT];
	row_t row_a_q;
	row_t row_b_q;
	node_t rd_a;
	node_t rd_b;
	logic  wr_en;
	node_t wr_addr;
	row_t  wr_row;

	// control state
	state_t state_q, state_d;
	lvl_t   lvl_q, lvl_d;
	node_t  clr_q, clr_d;
	logic   out_valid_q;

	// working registers
	node_t              x_q, x_d;     // first node, or the node being inserted
	node_t              y_q, y_d;     // second node, or the parent
	node_t              cur_q, cur_d; // ancestor reached by the insert chain
	depth_t             depth_q, depth_d;
	node_t [LEVELS-1:0] acc_q, acc_d; // jump levels of the inserted node
	node_t              out_node_q;

	logic          load_out;
	node_t         out_node_d;
	logic          out_free;
	logic [DEPTH_W:0] lift_step;
	node_t         chain_val;

	assign out_free  = !out_valid_q || rsp.ready;
	assign lift_step = {{DEPTH_W{1'b0}}, 1'b1} << lvl_q;

	// next ancestor of the insert chain; a self-reference reads the level
	// just built, which equals the current node
	assign chain_val = (cur_q == x_q) ? cur_q : row_a_q.jump[lvl_t'(lvl_q - 1'b1)];

	always_comb begin
		state_d    = state_q;
		lvl_d      = lvl_q;
		clr_d      = clr_q;
		x_d        = x_q;
		y_d        = y_q;
		cur_d      = cur_q;
		depth_d    = depth_q;
		acc_d      = acc_q;
		load_out   = 1'b0;
		out_node_d = x_q;
		wr_en      = 1'b0;
		wr_addr    = x_q;
		wr_row     = '0;
		rd_a       = x_q;
		rd_b       = y_q;

		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// start both row reads on the transaction itself
				rd_a = req.node_a;
				rd_b = req.node_b;
				x_d  = req.node_a;
				y_d  = req.node_b;
				if (req.valid) begin
					state_d = (req.action == ACT_QUERY) ? ST_Q_ORDER : ST_I_FIRST;
				end
			end
			ST_Q_ORDER: begin
				// deeper node goes to port a
				if (row_a_q.depth < row_b_q.depth) begin
					x_d = y_q;
					y_d = x_q;
				end
				rd_a    = x_d;
				rd_b    = y_d;
				lvl_d   = LVL_TOP;
				state_d = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				if ({1'b0, row_a_q.depth} >= {1'b0, row_b_q.depth} + lift_step) begin
					x_d = row_a_q.jump[lvl_q];
				end
				rd_a = x_d;
				if (lvl_q == '0) begin
					state_d = ST_Q_CHECK;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end
			ST_Q_CHECK: begin
				if (x_q == y_q) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					lvl_d   = LVL_TOP;
					state_d = ST_Q_CLIMB;
				end
			end
			ST_Q_CLIMB: begin
				if (row_a_q.jump[lvl_q] != row_b_q.jump[lvl_q]) begin
					x_d = row_a_q.jump[lvl_q];
					y_d = row_b_q.jump[lvl_q];
				end
				rd_a = x_d;
				rd_b = y_d;
				if (lvl_q == '0) begin
					state_d = ST_Q_FINAL;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end
			ST_Q_FINAL: begin
				out_node_d = row_a_q.jump[0];
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_I_FIRST: begin
				// parent row sits on port b
				depth_d  = (row_b_q.depth == DEPTH_MAX) ? DEPTH_MAX :
					row_b_q.depth + 1'b1;
				acc_d[0] = y_q;
				cur_d    = y_q;
				rd_a     = y_q;
				lvl_d    = lvl_t'(1);
				state_d  = ST_I_LEVEL;
			end
			ST_I_LEVEL: begin
				acc_d[lvl_q] = chain_val;
				cur_d        = chain_val;
				rd_a         = chain_val;
				if (lvl_q == LVL_TOP) begin
					state_d = ST_I_WRITE;
				end else begin
					lvl_d = lvl_q + 1'b1;
				end
			end
			ST_I_WRITE: begin
				// node zero is the sentinel and is never written by an insert
				wr_en        = (x_q != '0);
				wr_row.depth = depth_q;
				wr_row.jump  = acc_q;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory with registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		row_a_q <= mem[rd_a];
		row_b_q <= mem[rd_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			lvl_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			clr_q   <= clr_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q     <= x_d;
		y_q     <= y_d;
		cur_q   <= cur_d;
		depth_q <= depth_d;
		acc_q   <= acc_d;
		if (load_out) begin
			out_node_q <= out_node_d;
		end
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.ancestor = out_node_q;

endmodule

`default_nettype wire

// ----- rtl/lca_checker.sv -----
// port checker for the lowest common ancestor block, bound to every instance of the block
`default_nettype none

module lca_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           req_action,
	input wire lca_pkg::node_t req_node_a,
	input wire lca_pkg::node_t req_node_b,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire lca_pkg::node_t rsp_ancestor
);
	import lca_pkg::*;

	logic       q_acc;
	logic       r_acc;
	logic [1:0] pending_q;
	logic       exp_valid_q;
	node_t      exp_q;

	assign q_acc = req_valid && req_ready && (req_action == ACT_QUERY);
	assign r_acc = rsp_valid && rsp_ready;

	// queries in flight, and the known answer of a query of one node twice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			exp_valid_q <= 1'b0;
			exp_q       <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, q_acc} - {1'b0, r_acc};
			if (r_acc) begin
				exp_valid_q <= 1'b0;
			end
			if (q_acc && (pending_q == '0) && (req_node_a == req_node_b)) begin
				exp_valid_q <= 1'b1;
				exp_q       <= req_node_a;
			end
		end
	end

	a_rsp_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without an open query");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two queries in flight");

	a_same_node: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && exp_valid_q |-> rsp_ancestor == exp_q)
		else $error("query of one node twice did not return that node");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken in back-to-back cycles");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ancestor))
		else $error("stalled response changed");

endmodule

bind lca_binary_lifting lca_checker u_lca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_action   (req.action),
	.req_node_a   (req.node_a),
	.req_node_b   (req.node_b),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_ancestor (rsp.ancestor)
);

`default_nettype wire

// ----- verif/lca_binary_lifting_test.sv -----
// self-checking testbench of the binary lifting common ancestor block
`timescale 1ns / 1ps

module lca_binary_lifting_test;
	import lca_pkg::*;

	// run length and pacing
	localparam int RANDOM_ITEMS = 1883;
	localparam int LOOP_INSERTS = 40;     // self-inserts of one node, each one level deeper
	localparam node_t LOOP_NODE  = 12'd4094;
	localparam node_t LOOP_CHILD = 12'd4093;
	localparam int DRAIN_CYCLES = 40;
	// clearing pass plus about 1950 transactions with their busy steps, the sender gaps
	// and the receiver stalls, taken several times over
	localparam int CYCLE_LIMIT  = 500_000;

	// receiver stall patterns
	localparam int STALL_NONE = 0;
	localparam int STALL_COIN = 1;
	localparam int STALL_COMB = 2;

	// one row of the directed table: typed rows carry an expected ancestor read off by hand
	typedef struct packed {
		logic  action;
		node_t node_a;
		node_t node_b;
		logic  typed;
		node_t ancestor;
	} probe_t;

	localparam int PROBE_COUNT = 23;
	localparam probe_t PROBE_ROWS [PROBE_COUNT] = '{
		// empty stores: everything reads as sentinel, equal nodes answer themselves
		'{ACT_QUERY,  12'd0,    12'd0,    1'b1, 12'd0},
		'{ACT_QUERY,  12'd4095, 12'd4095, 1'b1, 12'd4095},
		'{ACT_QUERY,  12'd1,    12'd4095, 1'b1, 12'd0},
		// insert of the sentinel is dropped
		'{ACT_INSERT, 12'd0,    12'd5,    1'b0, 12'd0},
		'{ACT_QUERY,  12'd0,    12'd5,    1'b1, 12'd0},
		// small tree: 1 is the root, 4095 and 2 below it, 3 below 2
		'{ACT_INSERT, 12'd1,    12'd0,    1'b0, 12'd0},
		'{ACT_INSERT, 12'd4095, 12'd1,    1'b0, 12'd0},
		'{ACT_INSERT, 12'd2,    12'd1,    1'b0, 12'd0},
		'{ACT_INSERT, 12'd3,    12'd2,    1'b0, 12'd0},
		'{ACT_QUERY,  12'd3,    12'd4095, 1'b1, 12'd1},
		'{ACT_QUERY,  12'd4095, 12'd3,    1'b1, 12'd1},
		'{ACT_QUERY,  12'd3,    12'd1,    1'b1, 12'd1},
		'{ACT_QUERY,  12'd1,    12'd1,    1'b1, 12'd1},
		'{ACT_INSERT, 12'd2048, 12'd4095, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd2048, 12'd3,    1'b0, 12'd0},
		'{ACT_QUERY,  12'd2048, 12'd4095, 1'b0, 12'd0},
		// re-insert moves node 2, its child 3 keeps the stale ancestors
		'{ACT_INSERT, 12'd2,    12'd4095, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd3,    12'd2048, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd2,    12'd2048, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd0,    12'd1,    1'b0, 12'd0},
		// alternating bit patterns, parent never inserted
		'{ACT_INSERT, 12'd1365, 12'd2730, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd1365, 12'd2730, 1'b0, 12'd0},
		'{ACT_QUERY,  12'd2730, 12'd1365, 1'b0, 12'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	lca_req_if req_ch();
	lca_rsp_if rsp_ch();

	lca_binary_lifting DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #4 clk = ~clk;

	// predictor state: node depths and the ancestor 2^level steps up
	depth_t depth_mem [NODE_COUNT];
	node_t  hop_mem   [NODE_COUNT][LEVELS];

	node_t  pending_ancestors [$];   // answers of accepted queries, oldest first
	node_t  planted [$];             // nodes inserted by well-formed sequences
	node_t  wanted_ancestor;
	int     fail_count    = 0;
	int     insert_count  = 0;
	int     query_count   = 0;
	int     checked_count = 0;
	int     deepest       = 0;
	int     burst_left    = 0;
	int     cycle_count   = 0;

	// attach a node under its parent and rebuild every jump level from the one below
	function automatic void tree_insert(node_t n, node_t parent);
		int d;
		int i;
		if (n == 0) return;   // sentinel stays all zero
		d = depth_mem[parent] + 1;
		if (d > DEPTH_MAX) d = DEPTH_MAX;
		depth_mem[n] = depth_t'(d);
		if (d > deepest) deepest = d;
		hop_mem[n][0] = parent;
		for (i = 1; i < LEVELS; i++) hop_mem[n][i] = hop_mem[hop_mem[n][i-1]][i-1];
	endfunction

	// lift the deeper node to the other's depth, then both while their ancestors differ
	function automatic node_t common_ancestor(node_t p, node_t q);
		node_t x = p;
		node_t y = q;
		int i;
		if (depth_mem[x] < depth_mem[y]) begin
			x = q;
			y = p;
		end
		for (i = LEVELS - 1; i >= 0; i--)
			if (int'(depth_mem[x]) - (1 << i) >= int'(depth_mem[y])) x = hop_mem[x][i];
		if (x == y) return x;
		for (i = LEVELS - 1; i >= 0; i--)
			if (hop_mem[x][i] != hop_mem[y][i]) begin
				x = hop_mem[x][i];
				y = hop_mem[y][i];
			end
		return hop_mem[x][0];
	endfunction

	// present one transaction, wait for the handshake, then update the predictor;
	// the sender keeps valid high across a burst and drops it only for a real gap
	task automatic send_item(logic act, node_t a, node_t b, logic typed, node_t fixed);
		int gap;
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.node_a <= a;
		req_ch.node_b <= b;
		do @(posedge clk); while (!req_ch.ready);
		if (act == ACT_QUERY) begin
			pending_ancestors = {pending_ancestors, (typed ? fixed : common_ancestor(a, b))};
			query_count++;
		end else begin
			tree_insert(a, b);
			insert_count++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// pick a node from the grown trees, or a raw value while nothing is planted yet
	function automatic node_t pick_planted();
		if (planted.size() == 0) return node_t'($urandom_range(1, 4095));
		return planted[$urandom_range(0, planted.size() - 1)];
	endfunction

	// response side: ready follows one of three patterns, each held for a random stretch
	int stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_phase = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode  <= $urandom_range(STALL_NONE, STALL_COMB);
			stall_left  <= $urandom_range(16, 160);
		end else begin
			stall_left  <= stall_left - 1;
		end
		stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
		case (stall_mode)
			STALL_NONE: rsp_ch.ready <= 1'b1;
			STALL_COIN: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
			default:    rsp_ch.ready <= (stall_phase == 0);
		endcase
	end

	// compare each accepted response with the oldest pending answer
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_ancestors.size() == 0) begin
				$error("ancestor: no query pending, actual %0d", rsp_ch.ancestor);
				fail_count++;
			end else begin
				wanted_ancestor = pending_ancestors.pop_front();
				checked_count++;
				if (rsp_ch.ancestor !== wanted_ancestor) begin
					$error("ancestor: expected %0d, actual %0d", wanted_ancestor,
						rsp_ch.ancestor);
					fail_count++;
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lca_binary_lifting_test NOT OK");
			$finish;
		end
	end

	initial begin
		int i;
		int j;
		int r;
		node_t a;
		node_t b;

		for (i = 0; i < NODE_COUNT; i++) begin
			depth_mem[i] = '0;
			for (j = 0; j < LEVELS; j++) hop_mem[i][j] = '0;
		end

		req_ch.valid  = 1'b0;
		req_ch.action = ACT_INSERT;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its row memory first; send_item simply waits on ready

		// directed table
		for (i = 0; i < PROBE_COUNT; i++)
			send_item(PROBE_ROWS[i].action, PROBE_ROWS[i].node_a, PROBE_ROWS[i].node_b,
				PROBE_ROWS[i].typed, PROBE_ROWS[i].ancestor);

		// a node made its own parent deepens by one per insert
		for (i = 0; i < LOOP_INSERTS; i++)
			send_item(ACT_INSERT, LOOP_NODE, LOOP_NODE, 1'b0, '0);
		send_item(ACT_INSERT, LOOP_CHILD, LOOP_NODE, 1'b0, '0);
		send_item(ACT_QUERY, LOOP_NODE, 12'd1, 1'b0, '0);
		send_item(ACT_QUERY, LOOP_CHILD, LOOP_NODE, 1'b0, '0);
		send_item(ACT_QUERY, LOOP_CHILD, 12'd3, 1'b0, '0);
		planted = {planted, LOOP_NODE};
		planted = {planted, LOOP_CHILD};

		// random part: mostly growing trees parent first and querying them,
		// the rest raw noise that may break the parent-first order
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 42) begin
				a = node_t'($urandom_range(1, 4095));
				j = $urandom_range(0, 99);
				if (planted.size() == 0 || j < 8) b = '0;              // new root
				else if (j < 58) b = planted[planted.size() - 1];      // extend a chain
				else b = pick_planted();
				send_item(ACT_INSERT, a, b, 1'b0, '0);
				planted = {planted, a};
			end else if (r < 90) begin
				a = pick_planted();
				b = ($urandom_range(0, 9) == 0) ? a : pick_planted();
				send_item(ACT_QUERY, a, b, 1'b0, '0);
			end else begin
				send_item(logic'($urandom_range(0, 1)), node_t'($urandom_range(0, 4095)),
					node_t'($urandom_range(0, 4095)), 1'b0, '0);
			end
		end

		// end of stimulus: valid drops unless a gap already lowered it
		req_ch.valid <= 1'b0;
		while (pending_ancestors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d inserts and %0d queries, %0d answers checked",
			insert_count, query_count, checked_count);
		$display("deepest node reached depth %0d, %0d mismatches", deepest, fail_count);
		if (fail_count == 0)
			$display("lca_binary_lifting_test OK");
		else
			$display("lca_binary_lifting_test NOT OK");
		$finish;
	end

endmodule

// ----- lca_binary_lifting.f -----
rtl/lca_pkg.sv
rtl/lca_req_if.sv
rtl/lca_rsp_if.sv
rtl/lca_binary_lifting.sv
rtl/lca_checker.sv
verif/lca_binary_lifting_test.sv
